FILE: rtl/rotation_matrix_to_euler_core_defines.svh
// ----------------------------------------------------------------------------
// rotation matrix to euler core - assertion macros
// shared concurrent assertion forms, clocked on clk and held off during rst
// ----------------------------------------------------------------------------
`ifndef ROTATION_MATRIX_TO_EULER_CORE_DEFINES_SVH
`define ROTATION_MATRIX_TO_EULER_CORE_DEFINES_SVH

// same-cycle implication
`define RME_ASSERT_NOW(lbl, ant, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ant) |-> (cons)) else $error(msg);

// next-cycle implication
`define RME_ASSERT_NEXT(lbl, ant, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ant) |=> (cons)) else $error(msg);

`endif

FILE: rtl/rme_pkg.sv
// ----------------------------------------------------------------------------
// rme_pkg
// widths, constants, arctangent table and angle rounding for the core
// ----------------------------------------------------------------------------
package rme_pkg;

  localparam int CORDIC_STAGES_DEF = 16;
  localparam int ATAN_LEN          = 24;

  localparam int IN_W     = 18;   // cordic operand: q1.14 with headroom for sy and negation
  localparam int SCALE_SH = 16;   // operands scaled by 2^16
  localparam int XY_W     = 36;   // x/y datapath
  localparam int Z_W      = 34;   // q30 angle accumulator
  localparam int ANG_W    = 16;   // q2.13 angle
  localparam int LIM_W    = 15;
  localparam int SY_W     = 17;
  localparam int PROD_W   = XY_W + 16;

  localparam logic signed [Z_W-1:0]   HALF_PI_Q30  = 34'sd1686629713;
  localparam logic signed [ANG_W-1:0] ANGLE_MAX    = 16'sd25736;
  localparam logic [15:0]             INV_GAIN_Q16 = 16'd39797;
  localparam logic [PROD_W-1:0]       ROUND_HALF   = PROD_W'(64'h8000_0000);

  // register word indexes
  localparam logic [2:0] REG_SINGULAR_LIMIT = 3'd0;

  localparam logic signed [Z_W-1:0] ATAN_Q30 [ATAN_LEN] = '{
    34'sd843314857, 34'sd497837829, 34'sd263043837, 34'sd133525159,
    34'sd67021687,  34'sd33543516,  34'sd16775851,  34'sd8388437,
    34'sd4194283,   34'sd2097149,   34'sd1048576,   34'sd524288,
    34'sd262144,    34'sd131072,    34'sd65536,     34'sd32768,
    34'sd16384,     34'sd8192,      34'sd4096,      34'sd2048,
    34'sd1024,      34'sd512,       34'sd256,       34'sd128
  };

  // q30 radians to q2.13, halves rounded up, saturated at +-pi
  function automatic logic signed [ANG_W-1:0] to_q13(input logic signed [Z_W-1:0] z);
    logic signed [Z_W:0]    s;
    logic signed [Z_W-17:0] a;
    s = {z[Z_W-1], z} + (Z_W+1)'(65536);
    a = s[Z_W:17];
    if (a > (Z_W-16)'(ANGLE_MAX)) begin
      return ANGLE_MAX;
    end else if (a < -(Z_W-16)'(ANGLE_MAX)) begin
      return -ANGLE_MAX;
    end else begin
      return a[ANG_W-1:0];
    end
  endfunction

endpackage

FILE: rtl/rme_cordic.sv
// ----------------------------------------------------------------------------
// rme_cordic
// pipelined vectoring cordic, several lanes sharing one valid and one tag
// ----------------------------------------------------------------------------
module rme_cordic #(
  parameter int LANES  = 1,
  parameter int STAGES = rme_pkg::CORDIC_STAGES_DEF,
  parameter int TAG_W  = 1
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              en,
  input  logic                              in_valid,
  input  logic [TAG_W-1:0]                  in_tag,
  input  logic signed [rme_pkg::IN_W-1:0]   x_in [LANES],
  input  logic signed [rme_pkg::IN_W-1:0]   y_in [LANES],
  output logic                              out_valid,
  output logic [TAG_W-1:0]                  out_tag,
  output logic signed [rme_pkg::Z_W-1:0]    z_out [LANES],
  output logic signed [rme_pkg::XY_W-1:0]   mag_out
);
  import rme_pkg::*;

  localparam int N = (STAGES > ATAN_LEN) ? ATAN_LEN : STAGES;

  logic                   valid_q [N+1];
  logic [TAG_W-1:0]       tag_q   [N+1];
  logic                   zero_q  [N+1][LANES];
  logic signed [XY_W-1:0] x_q     [N+1][LANES];
  logic signed [XY_W-1:0] y_q     [N+1][LANES];
  logic signed [Z_W-1:0]  z_q     [N+1][LANES];

  logic signed [XY_W-1:0] x0 [LANES];
  logic signed [XY_W-1:0] y0 [LANES];
  logic signed [Z_W-1:0]  z0 [LANES];
  logic                   zero0 [LANES];

  // scale and fold the left half plane onto the right
  always_comb begin
    logic signed [XY_W-1:0] xs;
    logic signed [XY_W-1:0] ys;
    for (int l = 0; l < LANES; l++) begin
      xs = {{(XY_W-IN_W-SCALE_SH){x_in[l][IN_W-1]}}, x_in[l], {SCALE_SH{1'b0}}};
      ys = {{(XY_W-IN_W-SCALE_SH){y_in[l][IN_W-1]}}, y_in[l], {SCALE_SH{1'b0}}};
      zero0[l] = (x_in[l] == '0) && (y_in[l] == '0);
      if (xs[XY_W-1]) begin
        if (!ys[XY_W-1]) begin
          x0[l] = ys;
          y0[l] = -xs;
          z0[l] = HALF_PI_Q30;
        end else begin
          x0[l] = -ys;
          y0[l] = xs;
          z0[l] = -HALF_PI_Q30;
        end
      end else begin
        x0[l] = xs;
        y0[l] = ys;
        z0[l] = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i <= N; i++) begin
        valid_q[i] <= 1'b0;
      end
    end else if (en) begin
      valid_q[0] <= in_valid;
      for (int i = 0; i < N; i++) begin
        valid_q[i+1] <= valid_q[i];
      end
    end
  end

  // micro-rotations, one register stage each
  always_ff @(posedge clk) begin
    if (en) begin
      tag_q[0] <= in_tag;
      for (int l = 0; l < LANES; l++) begin
        x_q[0][l]    <= x0[l];
        y_q[0][l]    <= y0[l];
        z_q[0][l]    <= z0[l];
        zero_q[0][l] <= zero0[l];
      end
      for (int i = 0; i < N; i++) begin
        tag_q[i+1] <= tag_q[i];
        for (int l = 0; l < LANES; l++) begin
          zero_q[i+1][l] <= zero_q[i][l];
          if (!y_q[i][l][XY_W-1]) begin
            x_q[i+1][l] <= x_q[i][l] + (y_q[i][l] >>> i);
            y_q[i+1][l] <= y_q[i][l] - (x_q[i][l] >>> i);
            z_q[i+1][l] <= z_q[i][l] + ATAN_Q30[i];
          end else begin
            x_q[i+1][l] <= x_q[i][l] - (y_q[i][l] >>> i);
            y_q[i+1][l] <= y_q[i][l] + (x_q[i][l] >>> i);
            z_q[i+1][l] <= z_q[i][l] - ATAN_Q30[i];
          end
        end
      end
    end
  end

  assign out_valid = valid_q[N];
  assign out_tag   = tag_q[N];
  assign mag_out   = zero_q[N][0] ? '0 : x_q[N][0];

  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      z_out[l] = zero_q[N][l] ? '0 : z_q[N][l];
    end
  end

endmodule

FILE: rtl/rotation_matrix_to_euler_core.sv
// ----------------------------------------------------------------------------
// rotation_matrix_to_euler_core
// z-y-x euler angles from a q1.14 rotation matrix, fully pipelined cordic
// ----------------------------------------------------------------------------
//
//  channel  direction  handshake                   payload
//  input    in         in_valid / in_ready         m00 m10 m20 m21 m22 m11 m12
//  output   out        out_valid / out_ready       roll pitch yaw singular
//  config   in         apb psel/penable/pready     singular_limit at byte 0
//
//  one transfer accepted per cycle while the skid stage is empty; the two cordic
//  passes run in series (pitch needs sy from the first pass)
//  rst is synchronous: clears all valid bits and the skid stage, limit back to 1
//  a held result parks in the skid stage; the pipeline then freezes as a whole and
//  in_ready drops until the skid stage drains
//
module rotation_matrix_to_euler_core #(
  parameter int CORDIC_STAGES = rme_pkg::CORDIC_STAGES_DEF
) (
  input  logic               clk,
  input  logic               rst,
  // configuration
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  // input transfers
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [15:0] m00,
  input  logic signed [15:0] m10,
  input  logic signed [15:0] m20,
  input  logic signed [15:0] m21,
  input  logic signed [15:0] m22,
  input  logic signed [15:0] m11,
  input  logic signed [15:0] m12,
  // result transfers
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [15:0] roll,
  output logic signed [15:0] pitch,
  output logic signed [15:0] yaw,
  output logic               singular
);
  import rme_pkg::*;

  localparam int TAG2_W = 1 + 2 * ANG_W;

  // ---------------- configuration ----------------
  logic [LIM_W-1:0] singular_limit;
  logic             cfg_write;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      singular_limit <= LIM_W'(1);
    end else if (cfg_write && ((paddr >> 2) == REG_SINGULAR_LIMIT)) begin
      singular_limit <= pwdata[LIM_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if ((paddr >> 2) == REG_SINGULAR_LIMIT) begin
      prdata = {{(32-LIM_W){1'b0}}, singular_limit};
    end
  end

  // ---------------- global advance ----------------
  // the whole pipeline moves whenever the skid stage is empty
  logic en;
  logic skid_full;

  assign en       = !skid_full;
  assign in_ready = en;

  // ---------------- first pass: yaw, and both roll candidates ----------------
  // lane 0 gives yaw and the column magnitude, lane 1 the normal roll,
  // lane 2 the gimbal-lock roll; m20 rides along for pitch
  logic signed [IN_W-1:0]  p1_x [3];
  logic signed [IN_W-1:0]  p1_y [3];
  logic                    p1_valid;
  logic [15:0]             p1_m20;
  logic signed [Z_W-1:0]   p1_z [3];
  logic signed [XY_W-1:0]  p1_mag;

  assign p1_x[0] = {{2{m00[15]}}, m00};
  assign p1_y[0] = {{2{m10[15]}}, m10};
  assign p1_x[1] = {{2{m22[15]}}, m22};
  assign p1_y[1] = {{2{m21[15]}}, m21};
  assign p1_x[2] = {{2{m11[15]}}, m11};
  assign p1_y[2] = -{{2{m12[15]}}, m12};

  rme_cordic #(
    .LANES (3),
    .STAGES(CORDIC_STAGES),
    .TAG_W (16)
  ) u_cordic_a (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (in_valid),
    .in_tag   (m20),
    .x_in     (p1_x),
    .y_in     (p1_y),
    .out_valid(p1_valid),
    .out_tag  (p1_m20),
    .z_out    (p1_z),
    .mag_out  (p1_mag)
  );

  // ---------------- gain correction and angle rounding ----------------
  logic                    m_valid;
  logic [PROD_W-1:0]       m_prod;
  logic signed [ANG_W-1:0] m_yaw;
  logic signed [ANG_W-1:0] m_roll_n;
  logic signed [ANG_W-1:0] m_roll_s;
  logic [15:0]             m_m20;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_valid <= 1'b0;
    end else if (en) begin
      m_valid <= p1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      // sy scaled by 2^32, rounded at the half
      m_prod   <= PROD_W'($unsigned(p1_mag)) * PROD_W'(INV_GAIN_Q16) + ROUND_HALF;
      m_yaw    <= to_q13(p1_z[0]);
      m_roll_n <= to_q13(p1_z[1]);
      m_roll_s <= to_q13(p1_z[2]);
      m_m20    <= p1_m20;
    end
  end

  // ---------------- singular decision, second pass for pitch ----------------
  logic [SY_W-1:0]         sy;
  logic                    sing;
  logic signed [IN_W-1:0]  p2_x [1];
  logic signed [IN_W-1:0]  p2_y [1];
  logic [TAG2_W-1:0]       p2_tag_in;
  logic                    p2_valid;
  logic [TAG2_W-1:0]       p2_tag;
  logic signed [Z_W-1:0]   p2_z [1];

  assign sy      = m_prod[32 +: SY_W];
  assign sing    = sy < {{(SY_W-LIM_W){1'b0}}, singular_limit};
  assign p2_x[0] = {{(IN_W-SY_W){1'b0}}, sy};
  assign p2_y[0] = -{{2{m_m20[15]}}, m_m20};
  // gimbal lock picks the alternate roll and forces yaw to zero
  assign p2_tag_in = {sing, sing ? m_roll_s : m_roll_n, sing ? '0 : m_yaw};

  rme_cordic #(
    .LANES (1),
    .STAGES(CORDIC_STAGES),
    .TAG_W (TAG2_W)
  ) u_cordic_b (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (m_valid),
    .in_tag   (p2_tag_in),
    .x_in     (p2_x),
    .y_in     (p2_y),
    .out_valid(p2_valid),
    .out_tag  (p2_tag),
    .z_out    (p2_z),
    .mag_out  ()
  );

  // ---------------- final stage ----------------
  logic                    f_valid;
  logic signed [ANG_W-1:0] f_roll;
  logic signed [ANG_W-1:0] f_pitch;
  logic signed [ANG_W-1:0] f_yaw;
  logic                    f_sing;

  always_ff @(posedge clk) begin
    if (rst) begin
      f_valid <= 1'b0;
    end else if (en) begin
      f_valid <= p2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      f_pitch <= to_q13(p2_z[0]);
      f_sing  <= p2_tag[TAG2_W-1];
      f_roll  <= p2_tag[2*ANG_W-1:ANG_W];
      f_yaw   <= p2_tag[ANG_W-1:0];
    end
  end

  // ---------------- skid stage ----------------
  // catches the final stage when the result transfer stalls
  logic signed [ANG_W-1:0] s_roll;
  logic signed [ANG_W-1:0] s_pitch;
  logic signed [ANG_W-1:0] s_yaw;
  logic                    s_sing;

  always_ff @(posedge clk) begin
    if (rst) begin
      skid_full <= 1'b0;
    end else if (!skid_full) begin
      if (f_valid && !out_ready) begin
        skid_full <= 1'b1;
      end
    end else if (out_ready) begin
      skid_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!skid_full) begin
      s_roll  <= f_roll;
      s_pitch <= f_pitch;
      s_yaw   <= f_yaw;
      s_sing  <= f_sing;
    end
  end

  assign out_valid = skid_full || f_valid;
  assign roll      = skid_full ? s_roll  : f_roll;
  assign pitch     = skid_full ? s_pitch : f_pitch;
  assign yaw       = skid_full ? s_yaw   : f_yaw;
  assign singular  = skid_full ? s_sing  : f_sing;

endmodule

FILE: rtl/rme_checker.sv
// ----------------------------------------------------------------------------
// rme_checker
// port-level checks on the euler core, bound to the top level
// ----------------------------------------------------------------------------
`include "rotation_matrix_to_euler_core_defines.svh"

module rme_checker (
  input logic               clk,
  input logic               rst,
  input logic               pready,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic signed [15:0] roll,
  input logic signed [15:0] pitch,
  input logic signed [15:0] yaw,
  input logic               singular
);

  logic        angles_ok;
  logic [48:0] result_bits;

  assign angles_ok = (roll <= 16'sd25736) && (roll >= -16'sd25736) &&
                     (pitch <= 16'sd25736) && (pitch >= -16'sd25736) &&
                     (yaw <= 16'sd25736) && (yaw >= -16'sd25736);
  assign result_bits = {roll, pitch, yaw, singular};

  // gimbal lock never reports a yaw
  `RME_ASSERT_NOW(a_sing_yaw, out_valid && singular, yaw == 16'sd0, "yaw not zero when singular")

  // angles stay within +-pi
  `RME_ASSERT_NOW(a_range, out_valid, angles_ok, "angle beyond pi")

  // input only backs off while a result is waiting
  `RME_ASSERT_NOW(a_backpressure, !in_ready, out_valid && pready, "input stalled with no result waiting")

  // a stalled result stays on offer
  `RME_ASSERT_NEXT(a_hold, out_valid && !out_ready, out_valid && $stable(result_bits), "stalled result dropped or changed")

endmodule

bind rotation_matrix_to_euler_core rme_checker u_rme_checker (
  .clk      (clk),
  .rst      (rst),
  .pready   (pready),
  .in_ready (in_ready),
  .out_valid(out_valid),
  .out_ready(out_ready),
  .roll     (roll),
  .pitch    (pitch),
  .yaw      (yaw),
  .singular (singular)
);
